// ===== rtl/tfn_pkg.sv =====
// Package for the triangle face normal block: default parameter values,
// fixed internal widths and the record that rides along the square-root pipeline.
// No dependencies.
package tfn_pkg;

	localparam int COORD_WIDTH_DEF      = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// Width of the normalized cross-product magnitudes.
	localparam int NORM_BITS  = 31;
	// Width of the sum of squares and number of square-root steps.
	localparam int SUM_BITS   = 64;
	localparam int SQRT_STEPS = SUM_BITS / 2;
	// Width of the output normal components.
	localparam int NORMAL_WIDTH = 16;

	// Per-item data that travels beside the square root.
	typedef struct packed {
		logic [2:0][NORM_BITS-1:0] m;
		logic [2:0]                neg;
		logic                      degen;
	} tfn_carry_t;

endpackage

// ===== rtl/tfn_tri_if.sv =====
// Vertex input channel of the triangle face normal block: valid/ready and
// nine signed coordinates. Depends on tfn_pkg.
interface tfn_tri_if #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] p1_x;
	logic signed [COORD_WIDTH-1:0] p1_y;
	logic signed [COORD_WIDTH-1:0] p1_z;
	logic signed [COORD_WIDTH-1:0] p2_x;
	logic signed [COORD_WIDTH-1:0] p2_y;
	logic signed [COORD_WIDTH-1:0] p2_z;
	logic signed [COORD_WIDTH-1:0] p3_x;
	logic signed [COORD_WIDTH-1:0] p3_y;
	logic signed [COORD_WIDTH-1:0] p3_z;

	modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		p3_x, p3_y, p3_z, input ready);
	modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		p3_x, p3_y, p3_z, output ready);
endinterface

// ===== rtl/tfn_nrm_if.sv =====
// Normal output channel of the triangle face normal block: valid/ready,
// three signed normal components and the degenerate flag. Depends on tfn_pkg.
interface tfn_nrm_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [tfn_pkg::NORMAL_WIDTH-1:0]   normal_x;
	logic signed [tfn_pkg::NORMAL_WIDTH-1:0]   normal_y;
	logic signed [tfn_pkg::NORMAL_WIDTH-1:0]   normal_z;
	logic                                      degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate,
		input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
		output ready);
endinterface

// ===== rtl/triangle_face_normal.sv =====
// Top level of the triangle face normal block: a fully pipelined cross
// product, normalization, square root and rounding division.
// Depends on tfn_pkg, tfn_tri_if and tfn_nrm_if.
//
//   channel | direction | beat contents
//   --------+-----------+-----------------------------------------------
//   tri_in  | sink      | p1_x..p3_z, three vertices, COORD_WIDTH signed
//   nrm_out | source    | normal_x/y/z Q1.NORMAL_FRAC_BITS, degenerate
//
// One triangle can enter every cycle while the output is not stalled. The pipeline has
// eight front stages, one stage for each of the 32 square-root steps, one stage for each
// quotient bit and the output register.
// The stage counts of the square root and the division set the latency.
// Reset clears only the valid bits. The whole pipeline advances on one enable that is
// high whenever the output register is empty or being taken, so a stall freezes
// every stage and no beat is lost or repeated.
module triangle_face_normal #(
	parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
	parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tfn_tri_if.sink   tri_in,
	tfn_nrm_if.source nrm_out
);

	localparam int NB  = tfn_pkg::NORM_BITS;
	localparam int SB  = tfn_pkg::SUM_BITS;
	localparam int NS  = tfn_pkg::SQRT_STEPS;
	localparam int OW  = tfn_pkg::NORMAL_WIDTH;
	localparam int EW  = COORD_WIDTH + 1;        // edge width
	localparam int PW  = 2 * EW;                 // product width
	localparam int XW  = 2 * COORD_WIDTH + 3;    // cross component width
	localparam int LW  = $clog2(XW + 1);         // bit length code width
	localparam int QW  = NORMAL_FRAC_BITS + 2;   // quotient width
	localparam int NW  = NB + NORMAL_FRAC_BITS + 1; // dividend width
	localparam int LNW = NS;                     // square root width
	localparam int RW  = LNW + 1;                // partial remainder width

	// Global advance: the output register is empty or its beat is taken.
	logic en;
	assign en = !nrm_out.valid || nrm_out.ready;
	assign tri_in.ready = en;

	// Stage 1: edge vectors a = p1 - p2 and b = p1 - p3.
	logic                   v_s1;
	logic signed [EW-1:0]   a_s1 [3];
	logic signed [EW-1:0]   b_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= tri_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= EW'(tri_in.p1_x) - EW'(tri_in.p2_x);
			a_s1[1] <= EW'(tri_in.p1_y) - EW'(tri_in.p2_y);
			a_s1[2] <= EW'(tri_in.p1_z) - EW'(tri_in.p2_z);
			b_s1[0] <= EW'(tri_in.p1_x) - EW'(tri_in.p3_x);
			b_s1[1] <= EW'(tri_in.p1_y) - EW'(tri_in.p3_y);
			b_s1[2] <= EW'(tri_in.p1_z) - EW'(tri_in.p3_z);
		end
	end

	// Stage 2: the six partial products of the cross product.
	logic                 v_s2;
	logic signed [PW-1:0] prod_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2[0] <= PW'(a_s1[1]) * PW'(b_s1[2]);
			prod_s2[1] <= PW'(b_s1[1]) * PW'(a_s1[2]);
			prod_s2[2] <= PW'(b_s1[0]) * PW'(a_s1[2]);
			prod_s2[3] <= PW'(a_s1[0]) * PW'(b_s1[2]);
			prod_s2[4] <= PW'(a_s1[0]) * PW'(b_s1[1]);
			prod_s2[5] <= PW'(b_s1[0]) * PW'(a_s1[1]);
		end
	end

	// Stage 3: cross product components, exact.
	logic                 v_s3;
	logic signed [XW-1:0] c_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= XW'(prod_s2[2*i]) - XW'(prod_s2[2*i+1]);
			end
		end
	end

	// Stage 4: sign and magnitude of each component.
	logic          v_s4;
	logic [XW-1:0] mag_s4 [3];
	logic [2:0]    neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= c_s3[i][XW-1];
				mag_s4[i] <= c_s3[i][XW-1] ? XW'(-c_s3[i]) : XW'(c_s3[i]);
			end
		end
	end

	// Stage 5: bit length of the largest magnitude, found on the OR of all three.
	logic          v_s5;
	logic [XW-1:0] mag_s5 [3];
	logic [2:0]    neg_s5;
	logic [LW-1:0] len_bits_s5;
	logic [XW-1:0] mag_or;
	logic [LW-1:0] len_bits;

	always_comb begin
		mag_or   = mag_s4[0] | mag_s4[1] | mag_s4[2];
		len_bits = '0;
		for (int i = 0; i < XW; i++) begin
			if (mag_or[i]) begin
				len_bits = LW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5      <= mag_s4;
			neg_s5      <= neg_s4;
			len_bits_s5 <= len_bits;
		end
	end

	// Stage 6: scale so the largest magnitude has exactly NB bits. Placing the
	// magnitude NB bits up and shifting right by its length does both the exact
	// left shift and the truncating right shift.
	logic               v_s6;
	tfn_pkg::tfn_carry_t cr_s6;
	logic [XW+NB-1:0]   scaled [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = {mag_s5[i], NB'(0)} >> len_bits_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cr_s6.m[i] <= scaled[i][NB-1:0];
			end
			cr_s6.neg   <= neg_s5;
			cr_s6.degen <= (len_bits_s5 == '0);
		end
	end

	// Stage 7: squares.
	logic                v_s7;
	tfn_pkg::tfn_carry_t cr_s7;
	logic [2*NB-1:0]     sq_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s7 <= cr_s6;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= (2*NB)'(cr_s6.m[i]) * (2*NB)'(cr_s6.m[i]);
			end
		end
	end

	// Stage 8: sum of squares, below 2^64.
	logic                v_s8;
	tfn_pkg::tfn_carry_t cr_s8;
	logic [SB-1:0]       sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s8  <= cr_s7;
			sum_s8 <= SB'(sq_s7[0]) + SB'(sq_s7[1]) + SB'(sq_s7[2]);
		end
	end

	// Square root: one digit-by-digit step per stage. Starting at the top bit
	// even for small sums gives the same floor root.
	logic                sr_v_s   [NS];
	logic [SB-1:0]       sr_rem_s [NS];
	logic [SB-1:0]       sr_res_s [NS];
	tfn_pkg::tfn_carry_t sr_cr_s  [NS];

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [SB-1:0] BIT_K = SB'(1) << (SB - 2 - 2*k);
		logic                prv_v;
		logic [SB-1:0]       prv_rem;
		logic [SB-1:0]       prv_res;
		tfn_pkg::tfn_carry_t prv_cr;
		logic [SB-1:0]       trial;

		if (k == 0) begin : g_first
			assign prv_v   = v_s8;
			assign prv_rem = sum_s8;
			assign prv_res = '0;
			assign prv_cr  = cr_s8;
		end else begin : g_next
			assign prv_v   = sr_v_s[k-1];
			assign prv_rem = sr_rem_s[k-1];
			assign prv_res = sr_res_s[k-1];
			assign prv_cr  = sr_cr_s[k-1];
		end

		assign trial = prv_res + BIT_K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v_s[k] <= 1'b0;
			end else if (en) begin
				sr_v_s[k] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr_cr_s[k] <= prv_cr;
				if (prv_rem >= trial) begin
					sr_rem_s[k] <= prv_rem - trial;
					sr_res_s[k] <= (prv_res >> 1) + BIT_K;
				end else begin
					sr_rem_s[k] <= prv_rem;
					sr_res_s[k] <= prv_res >> 1;
				end
			end
		end
	end

	// Rounding division: dividend m * 2^F + floor(len / 2), one quotient bit
	// per stage for all three lanes. The top dividend bits are always below len.
	logic [LNW-1:0] root_len;
	logic [NW-1:0]  dividend [3];

	assign root_len = sr_res_s[NS-1][LNW-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dividend[i] = {1'b0, sr_cr_s[NS-1].m[i], NORMAL_FRAC_BITS'(0)}
				+ NW'(root_len >> 1);
		end
	end

	logic           dv_v_s     [QW];
	logic [RW-1:0]  dv_rem_s   [QW][3];
	logic [NW-1:0]  dv_num_s   [QW][3];
	logic [QW-1:0]  dv_q_s     [QW][3];
	logic [LNW-1:0] dv_len_s   [QW];
	logic [2:0]     dv_neg_s   [QW];
	logic           dv_degen_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int BIT_IDX = QW - 1 - j;
		logic           prv_v;
		logic [RW-1:0]  prv_rem [3];
		logic [NW-1:0]  prv_num [3];
		logic [QW-1:0]  prv_q   [3];
		logic [LNW-1:0] prv_len;
		logic [2:0]     prv_neg;
		logic           prv_degen;
		logic [RW-1:0]  trial   [3];

		if (j == 0) begin : g_first
			assign prv_v     = sr_v_s[NS-1];
			assign prv_len   = root_len;
			assign prv_neg   = sr_cr_s[NS-1].neg;
			assign prv_degen = sr_cr_s[NS-1].degen;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign prv_rem[i] = RW'(dividend[i][NW-1:QW]);
				assign prv_num[i] = dividend[i];
				assign prv_q[i]   = '0;
			end
		end else begin : g_next
			assign prv_v     = dv_v_s[j-1];
			assign prv_len   = dv_len_s[j-1];
			assign prv_neg   = dv_neg_s[j-1];
			assign prv_degen = dv_degen_s[j-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign prv_rem[i] = dv_rem_s[j-1][i];
				assign prv_num[i] = dv_num_s[j-1][i];
				assign prv_q[i]   = dv_q_s[j-1][i];
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = {prv_rem[i][RW-2:0], prv_num[i][BIT_IDX]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len_s[j]   <= prv_len;
				dv_neg_s[j]   <= prv_neg;
				dv_degen_s[j] <= prv_degen;
				for (int i = 0; i < 3; i++) begin
					dv_num_s[j][i] <= prv_num[i];
					if (trial[i] >= RW'(prv_len)) begin
						dv_rem_s[j][i] <= trial[i] - RW'(prv_len);
						dv_q_s[j][i]   <= prv_q[i] | (QW'(1) << BIT_IDX);
					end else begin
						dv_rem_s[j][i] <= trial[i];
						dv_q_s[j][i]   <= prv_q[i];
					end
				end
			end
		end
	end

	// Output register: saturate, restore the sign, and zero a degenerate normal.
	localparam int CW2 = (QW > OW + 1) ? QW : OW + 1;
	localparam logic [CW2-1:0] Q_LIMIT = CW2'(1) << (OW - 1);
	localparam logic [CW2-1:0] POS_MAX = Q_LIMIT - CW2'(1);

	logic [CW2-1:0]        q_sat [3];
	logic signed [OW-1:0]  comp  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_sat[i] = (CW2'(dv_q_s[QW-1][i]) > Q_LIMIT) ? Q_LIMIT
				: CW2'(dv_q_s[QW-1][i]);
			if (dv_degen_s[QW-1]) begin
				comp[i] = '0;
			end else if (dv_neg_s[QW-1][i]) begin
				comp[i] = OW'(-q_sat[i]);
			end else if (q_sat[i] > POS_MAX) begin
				comp[i] = OW'(POS_MAX);
			end else begin
				comp[i] = OW'(q_sat[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_out.valid <= 1'b0;
		end else if (en) begin
			nrm_out.valid <= dv_v_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_out.normal_x   <= comp[0];
			nrm_out.normal_y   <= comp[1];
			nrm_out.normal_z   <= comp[2];
			nrm_out.degenerate <= dv_degen_s[QW-1];
		end
	end

	// The input side may take a beat exactly when the pipeline advances.
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		tri_in.ready == (!nrm_out.valid || nrm_out.ready))
		else $error("input ready does not follow the output stall");

	// A degenerate triangle reports an all-zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(nrm_out.valid && nrm_out.degenerate) |->
		(nrm_out.normal_x == '0 && nrm_out.normal_y == '0 && nrm_out.normal_z == '0))
		else $error("degenerate beat carries a nonzero normal");

	// A proper unit normal can never have all three components zero.
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(nrm_out.valid && !nrm_out.degenerate) |->
		(nrm_out.normal_x != '0 || nrm_out.normal_y != '0 || nrm_out.normal_z != '0))
		else $error("nondegenerate beat carries a zero normal");

endmodule
